/* rtl/lrip_pkg.sv */
// Package for the lidar range image projection block.
// Holds shared widths, register indexes, reset values and the CORDIC angle table.
// No dependencies.
package lrip_pkg;

   // Default sizes for the top level parameters.
   localparam int DEF_MAX_ROWS   = 32;
   localparam int DEF_MAX_COLS   = 512;
   localparam int DEF_COORD_BITS = 20;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] REG_VFOV = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HFOV = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROWS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COLS = 3'd3;

   localparam logic [7:0] RST_VFOV = 8'd30;
   localparam logic [8:0] RST_HFOV = 9'd360;
   localparam logic [5:0] RST_ROWS = 6'd30;
   localparam logic [9:0] RST_COLS = 10'd360;

   // Operation codes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // Datapath widths.
   localparam int CORDIC_ITERS = 20;
   localparam int ANG_W        = 26;   // signed degrees, 16 fraction bits
   localparam int MUL_W        = 28;   // shared multiplier operand width
   localparam int DIV_W        = 40;   // dividend and quotient width
   localparam int DEN_W        = 26;   // divisor remainder width
   localparam logic signed [ANG_W-1:0] ANG_180 = 26'sd11796480;

   // atan(2^-i) in degrees with 16 fraction bits, rounded to nearest.
   function automatic logic signed [ANG_W-1:0] atan_step(input logic [4:0] i);
      logic signed [ANG_W-1:0] v;
      case (i)
         5'd0:    v = 26'sd2949120;
         5'd1:    v = 26'sd1740967;
         5'd2:    v = 26'sd919879;
         5'd3:    v = 26'sd466945;
         5'd4:    v = 26'sd234378;
         5'd5:    v = 26'sd117304;
         5'd6:    v = 26'sd58666;
         5'd7:    v = 26'sd29335;
         5'd8:    v = 26'sd14668;
         5'd9:    v = 26'sd7334;
         5'd10:   v = 26'sd3667;
         5'd11:   v = 26'sd1833;
         5'd12:   v = 26'sd917;
         5'd13:   v = 26'sd458;
         5'd14:   v = 26'sd229;
         5'd15:   v = 26'sd115;
         5'd16:   v = 26'sd57;
         5'd17:   v = 26'sd29;
         5'd18:   v = 26'sd14;
         5'd19:   v = 26'sd7;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/lrip_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module lrip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lidar_range_image_projection.sv */
// Top level of the lidar range image projection block.
// Depends on lrip_pkg and lrip_ram.

// The block keeps a range image in one RAM of 2^(ROW_W + COL_W) cells. After
// reset it first sweeps the RAM to mark every cell empty, one cell per cycle;
// requests wait until the sweep is done, while register writes are taken at any time.
// Items are handled one at a time. The square root for the horizontal range and the
// 40-step divisions that place the row and column each run one bit per cycle. A
// finished result waits in the output register while the next request is taken.
module lidar_range_image_projection #(
   parameter int MAX_ROWS   = lrip_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = lrip_pkg::DEF_MAX_COLS,
   parameter int COORD_BITS = lrip_pkg::DEF_COORD_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [lrip_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lrip_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic signed [COORD_BITS-1:0]          req_point_x,
   input  logic signed [COORD_BITS-1:0]          req_point_y,
   input  logic signed [COORD_BITS-1:0]          req_point_z,
   input  logic [15:0]                           req_point_intensity,
   input  logic                                  req_point_finite,
   input  logic [4:0]                            req_read_row,
   input  logic [8:0]                            req_read_col,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_cell_valid,
   output logic signed [COORD_BITS-1:0]          rsp_cell_x,
   output logic signed [COORD_BITS-1:0]          rsp_cell_y,
   output logic signed [COORD_BITS-1:0]          rsp_cell_z,
   output logic [15:0]                           rsp_cell_intensity,
   output logic [4:0]                            rsp_target_row,
   output logic [8:0]                            rsp_target_col,
   output logic                                  rsp_was_written
);

   localparam int C      = COORD_BITS;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int NR_W   = $clog2(MAX_ROWS + 1);
   localparam int NC_W   = $clog2(MAX_COLS + 1);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int E_W    = 1 + 3 * C + 16;
   localparam int D2_W   = 2 * C;
   localparam int RAD_W  = 2 * C + 16;
   localparam int RT_W   = C + 8;
   localparam int CW     = C + 11;
   localparam int MW     = lrip_pkg::MUL_W;
   localparam int PW     = 2 * lrip_pkg::MUL_W;
   localparam int AW     = lrip_pkg::ANG_W;
   localparam int DW     = lrip_pkg::DIV_W;
   localparam int NW     = lrip_pkg::DEN_W;

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_SQ       = 4'd2;
   localparam logic [3:0] ST_SQRT     = 4'd3;
   localparam logic [3:0] ST_AZ_INIT  = 4'd4;
   localparam logic [3:0] ST_CORD     = 4'd5;
   localparam logic [3:0] ST_EL_INIT  = 4'd6;
   localparam logic [3:0] ST_ROW_MUL  = 4'd7;
   localparam logic [3:0] ST_DIV_PREP = 4'd8;
   localparam logic [3:0] ST_DIV      = 4'd9;
   localparam logic [3:0] ST_COL_MUL  = 4'd10;
   localparam logic [3:0] ST_MEM_RD   = 4'd11;
   localparam logic [3:0] ST_MEM_CHK  = 4'd12;
   localparam logic [3:0] ST_DIST     = 4'd13;
   localparam logic [3:0] ST_WRITE    = 4'd14;
   localparam logic [3:0] ST_DONE     = 4'd15;

   // Configuration registers.
   logic [7:0] vfov_ff;
   logic [8:0] hfov_ff;
   logic [5:0] rows_ff;
   logic [9:0] cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vfov_ff <= lrip_pkg::RST_VFOV;
         hfov_ff <= lrip_pkg::RST_HFOV;
         rows_ff <= lrip_pkg::RST_ROWS;
         cols_ff <= lrip_pkg::RST_COLS;
      end else if (csr_we) begin
         case (csr_index)
            lrip_pkg::REG_VFOV: vfov_ff <= csr_wdata[7:0];
            lrip_pkg::REG_HFOV: hfov_ff <= csr_wdata[8:0];
            lrip_pkg::REG_ROWS: rows_ff <= csr_wdata[5:0];
            lrip_pkg::REG_COLS: cols_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // Control and working registers.
   logic [3:0]              state_ff;
   logic [5:0]              cnt_ff;
   logic [ADDR_W-1:0]       clr_ff;
   logic                    op_read_ff;
   logic                    phase_el_ff;
   logic                    div_col_ff;
   logic signed [C-1:0]     x_ff, y_ff, z_ff;
   logic [15:0]             inten_ff;
   logic [7:0]              vf_ff;
   logic [8:0]              hf_ff;
   logic [NR_W-1:0]         nr_ff;
   logic [NC_W-1:0]         nc_ff;
   logic [D2_W-1:0]         acc_ff;
   logic [D2_W-1:0]         d2_ff;
   logic [RAD_W-1:0]        rad_ff;
   logic [RT_W:0]           rem_ff;
   logic [RT_W-1:0]         root_ff;
   logic signed [CW-1:0]    cx_ff, cy_ff;
   logic signed [AW-1:0]    ang_ff, az_ff, el_ff;
   logic                    ang_zero_ff;
   logic signed [PW-1:0]    num_ff;
   logic [DW-1:0]           n_ff;
   logic [NW-1:0]           drem_ff;
   logic [NW:0]             dd_ff;
   logic                    neg_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [ADDR_W-1:0]       addr_ff;
   logic                    res_valid_ff;
   logic signed [C-1:0]     res_x_ff, res_y_ff, res_z_ff;
   logic [15:0]             res_inten_ff;
   logic [4:0]              res_row_ff;
   logic [8:0]              res_col_ff;
   logic                    res_wr_ff;
   logic                    rsp_valid_ff;

   // Memory entry: occupied flag, x, y, z, intensity.
   logic [E_W-1:0]    rd_data;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [E_W-1:0]    mem_wdata;
   logic              ent_occ;
   logic signed [C-1:0] ent_x, ent_y, ent_z;
   logic [15:0]       ent_inten;

   assign ent_occ   = rd_data[E_W-1];
   assign ent_x     = rd_data[E_W-2 -: C];
   assign ent_y     = rd_data[E_W-2-C -: C];
   assign ent_z     = rd_data[E_W-2-2*C -: C];
   assign ent_inten = rd_data[15:0];

   lrip_ram #(
      .WIDTH (E_W),
      .DEPTH (DEPTH)
   ) u_image_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         ST_MEM_CHK: begin
            // A read clears the cell it returns.
            mem_we = op_read_ff;
         end
         ST_WRITE: begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, x_ff, y_ff, z_ff, inten_ff};
         end
         default: ;
      endcase
   end

   // Shared multiplier for squares and the row and column scaling.
   logic signed [MW-1:0] op_a, op_b;
   logic signed [PW-1:0] prod;
   logic signed [AW:0]   row_diff, col_sum;

   assign row_diff = $signed({{(AW-22){1'b0}}, vf_ff, 15'd0}) - {el_ff[AW-1], el_ff};
   assign col_sum  = {az_ff[AW-1], az_ff} + $signed({{(AW-23){1'b0}}, hf_ff, 15'd0});

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_SQ: begin
            if (cnt_ff == 6'd0) begin
               op_a = MW'(x_ff);
            end else if (cnt_ff == 6'd1) begin
               op_a = MW'(y_ff);
            end else begin
               op_a = MW'(z_ff);
            end
            op_b = op_a;
         end
         ST_DIST: begin
            if (cnt_ff == 6'd0) begin
               op_a = MW'(ent_x);
            end else if (cnt_ff == 6'd1) begin
               op_a = MW'(ent_y);
            end else begin
               op_a = MW'(ent_z);
            end
            op_b = op_a;
         end
         ST_ROW_MUL: begin
            op_a = $signed(MW'(nr_ff));
            op_b = MW'(row_diff);
         end
         ST_COL_MUL: begin
            op_a = $signed(MW'(nc_ff));
            op_b = MW'(col_sum);
         end
         default: ;
      endcase
   end

   assign prod = op_a * op_b;

   // Square root step: two radicand bits per cycle, trial value 4 * root + 1.
   logic [RT_W+2:0] sq_rem, sq_trial;
   assign sq_rem   = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};

   // CORDIC vectoring step.
   logic signed [CW-1:0] cx_sh, cy_sh;
   logic                 cy_pos;
   logic signed [AW-1:0] step_ang;
   assign cx_sh    = cx_ff >>> cnt_ff[4:0];
   assign cy_sh    = cy_ff >>> cnt_ff[4:0];
   assign cy_pos   = !cy_ff[CW-1] && (cy_ff != '0);
   assign step_ang = lrip_pkg::atan_step(cnt_ff[4:0]);

   // Restoring division step and final clamp.
   logic [NW:0]     div_sh;
   logic            div_bit;
   logic [DW-1:0]   quot;
   logic [DW-1:0]   lim;
   logic [DW-1:0]   idx;
   assign div_sh  = {drem_ff, n_ff[DW-1]};
   assign div_bit = (div_sh >= dd_ff);
   assign quot    = {n_ff[DW-2:0], div_bit};
   assign lim     = div_col_ff ? DW'(nc_ff - NC_W'(1)) : DW'(nr_ff - NR_W'(1));

   always_comb begin
      if (neg_ff && quot != '0) begin
         idx = '0;
      end else if (quot > lim) begin
         idx = lim;
      end else begin
         idx = quot;
      end
   end

   // Setup values for the division.
   logic [DW-1:0]   num_mag;
   logic [NW-1:0]   den;
   assign num_mag = num_ff[PW-1] ? DW'(-num_ff) : DW'(num_ff);
   assign den     = div_col_ff ? {1'b0, hf_ff, 16'd0} : {2'b00, vf_ff, 16'd0};

   // Scaled CORDIC inputs.
   logic signed [CW-1:0] xs, ys, zs;
   assign xs = {{(CW-C-8){x_ff[C-1]}}, x_ff, 8'd0};
   assign ys = {{(CW-C-8){y_ff[C-1]}}, y_ff, 8'd0};
   assign zs = {{(CW-C-8){z_ff[C-1]}}, z_ff, 8'd0};

   logic [D2_W-1:0] acc_sum;
   assign acc_sum = acc_ff + D2_W'(prod);

   logic req_in_range;
   assign req_in_range = (32'(req_read_row) < MAX_ROWS) && (32'(req_read_col) < MAX_COLS);

   logic rsp_free;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
               if (clr_ff == {ADDR_W{1'b1}}) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  op_read_ff   <= req_operation;
                  x_ff         <= req_point_x;
                  y_ff         <= req_point_y;
                  z_ff         <= req_point_z;
                  inten_ff     <= req_point_intensity;
                  vf_ff        <= (vfov_ff == '0) ? 8'd1 : vfov_ff;
                  hf_ff        <= (hfov_ff == '0) ? 9'd1 : hfov_ff;
                  if (rows_ff == '0) begin
                     nr_ff <= NR_W'(1);
                  end else if (32'(rows_ff) > MAX_ROWS) begin
                     nr_ff <= NR_W'(MAX_ROWS);
                  end else begin
                     nr_ff <= NR_W'(rows_ff);
                  end
                  if (cols_ff == '0) begin
                     nc_ff <= NC_W'(1);
                  end else if (32'(cols_ff) > MAX_COLS) begin
                     nc_ff <= NC_W'(MAX_COLS);
                  end else begin
                     nc_ff <= NC_W'(cols_ff);
                  end
                  res_valid_ff <= 1'b0;
                  res_x_ff     <= '0;
                  res_y_ff     <= '0;
                  res_z_ff     <= '0;
                  res_inten_ff <= '0;
                  res_row_ff   <= '0;
                  res_col_ff   <= '0;
                  res_wr_ff    <= 1'b0;
                  cnt_ff       <= '0;
                  acc_ff       <= '0;
                  if (req_operation == lrip_pkg::OP_READ) begin
                     res_row_ff <= req_read_row;
                     res_col_ff <= req_read_col;
                     addr_ff    <= {ROW_W'(req_read_row), COL_W'(req_read_col)};
                     state_ff   <= req_in_range ? ST_MEM_RD : ST_DONE;
                  end else begin
                     state_ff <= req_point_finite ? ST_SQ : ST_DONE;
                  end
               end
            end
            ST_SQ: begin
               acc_ff <= acc_sum;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd1) begin
                  rad_ff <= {acc_sum, 16'd0};
               end
               if (cnt_ff == 6'd2) begin
                  d2_ff    <= acc_sum;
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
               if (sq_rem >= sq_trial) begin
                  rem_ff  <= (RT_W+1)'(sq_rem - sq_trial);
                  root_ff <= {root_ff[RT_W-2:0], 1'b1};
               end else begin
                  rem_ff  <= (RT_W+1)'(sq_rem);
                  root_ff <= {root_ff[RT_W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(RT_W - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_AZ_INIT;
               end
            end
            ST_AZ_INIT: begin
               phase_el_ff <= 1'b0;
               ang_zero_ff <= (x_ff == '0) && (y_ff == '0);
               if (x_ff[C-1]) begin
                  // Left half plane: fold by 180 degrees first.
                  ang_ff <= y_ff[C-1] ? -lrip_pkg::ANG_180 : lrip_pkg::ANG_180;
                  cx_ff  <= -xs;
                  cy_ff  <= -ys;
               end else begin
                  ang_ff <= '0;
                  cx_ff  <= xs;
                  cy_ff  <= ys;
               end
               cnt_ff   <= '0;
               state_ff <= ST_CORD;
            end
            ST_CORD: begin
               if (cy_pos) begin
                  cx_ff  <= cx_ff + cy_sh;
                  cy_ff  <= cy_ff - cx_sh;
                  ang_ff <= ang_ff + step_ang;
               end else begin
                  cx_ff  <= cx_ff - cy_sh;
                  cy_ff  <= cy_ff + cx_sh;
                  ang_ff <= ang_ff - step_ang;
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(lrip_pkg::CORDIC_ITERS - 1)) begin
                  cnt_ff <= '0;
                  if (phase_el_ff) begin
                     el_ff    <= ang_zero_ff ? '0 : ang_ff - (cy_pos ? -step_ang : step_ang);
                     state_ff <= ST_ROW_MUL;
                  end else begin
                     az_ff    <= ang_zero_ff ? '0 : ang_ff - (cy_pos ? -step_ang : step_ang);
                     state_ff <= ST_EL_INIT;
                  end
               end
            end
            ST_EL_INIT: begin
               phase_el_ff <= 1'b1;
               ang_zero_ff <= (root_ff == '0) && (z_ff == '0);
               ang_ff      <= '0;
               cx_ff       <= CW'(root_ff);
               cy_ff       <= zs;
               cnt_ff      <= '0;
               state_ff    <= ST_CORD;
            end
            ST_ROW_MUL: begin
               num_ff     <= prod;
               div_col_ff <= 1'b0;
               state_ff   <= ST_DIV_PREP;
            end
            ST_COL_MUL: begin
               num_ff     <= prod;
               div_col_ff <= 1'b1;
               state_ff   <= ST_DIV_PREP;
            end
            ST_DIV_PREP: begin
               // Round half away from zero: (2|num| + den) / (2 den).
               neg_ff   <= num_ff[PW-1];
               n_ff     <= {num_mag[DW-2:0], 1'b0} + DW'(den);
               dd_ff    <= {den, 1'b0};
               drem_ff  <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               drem_ff <= div_bit ? NW'(div_sh - dd_ff) : NW'(div_sh);
               n_ff    <= quot;
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(DW - 1)) begin
                  cnt_ff <= '0;
                  if (div_col_ff) begin
                     addr_ff    <= {row_ff, COL_W'(idx)};
                     res_col_ff <= 9'(idx);
                     state_ff   <= ST_MEM_RD;
                  end else begin
                     row_ff     <= ROW_W'(idx);
                     res_row_ff <= 5'(idx);
                     state_ff   <= ST_COL_MUL;
                  end
               end
            end
            ST_MEM_RD: begin
               state_ff <= ST_MEM_CHK;
            end
            ST_MEM_CHK: begin
               if (op_read_ff) begin
                  if (ent_occ) begin
                     res_valid_ff <= 1'b1;
                     res_x_ff     <= ent_x;
                     res_y_ff     <= ent_y;
                     res_z_ff     <= ent_z;
                     res_inten_ff <= ent_inten;
                  end
                  state_ff <= ST_DONE;
               end else if (!ent_occ) begin
                  state_ff <= ST_WRITE;
               end else begin
                  acc_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIST;
               end
            end
            ST_DIST: begin
               acc_ff <= acc_sum;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd2) begin
                  cnt_ff   <= '0;
                  state_ff <= (d2_ff < acc_sum) ? ST_WRITE : ST_DONE;
               end
            end
            ST_WRITE: begin
               res_wr_ff <= 1'b1;
               state_ff  <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Output register, loaded when a result is handed over.
   logic                rsp_cell_valid_ff;
   logic signed [C-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [15:0]         rsp_inten_ff;
   logic [4:0]          rsp_row_ff;
   logic [8:0]          rsp_col_ff;
   logic                rsp_wr_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_cell_valid_ff <= res_valid_ff;
         rsp_x_ff          <= res_x_ff;
         rsp_y_ff          <= res_y_ff;
         rsp_z_ff          <= res_z_ff;
         rsp_inten_ff      <= res_inten_ff;
         rsp_row_ff        <= res_row_ff;
         rsp_col_ff        <= res_col_ff;
         rsp_wr_ff         <= res_wr_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_valid     = rsp_cell_valid_ff;
   assign rsp_cell_x         = rsp_x_ff;
   assign rsp_cell_y         = rsp_y_ff;
   assign rsp_cell_z         = rsp_z_ff;
   assign rsp_cell_intensity = rsp_inten_ff;
   assign rsp_target_row     = rsp_row_ff;
   assign rsp_target_col     = rsp_col_ff;
   assign rsp_was_written    = rsp_wr_ff;

endmodule
